>>> rtl/first_fit_heap_allocator_macros.svh
// Assertion macros for the first-fit heap allocator checker.
// Used by ffha_checker.sv only.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FFHA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ffha assertion failed");

// Next-cycle implication, disabled during reset.
`define FFHA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ffha assertion failed");

`endif

>>> rtl/ffha_pkg.sv
// Shared constants, types and codes for the first-fit heap allocator.
// No dependencies.
`timescale 1ns / 1ps

package ffha_pkg;

   localparam int MAX_BLOCKS = 64;
   localparam int HEAP_BYTES = 16777216;
   localparam int PAGE_BYTES = 4096;

   localparam int IDX_W    = $clog2(MAX_BLOCKS);
   localparam int CNT_W    = $clog2(MAX_BLOCKS + 1);
   localparam int UNIT_W   = 21;
   localparam int OFF_W    = 27;
   localparam int TOP_W    = $clog2(HEAP_BYTES + 1);
   localparam int PAGE_LOG = $clog2(PAGE_BYTES);
   localparam int GROW_W   = OFF_W - PAGE_LOG;
   localparam int REL_W    = UNIT_W + 4 - PAGE_LOG;
   localparam int TPG_W    = TOP_W - PAGE_LOG;
   localparam int ENT_W    = UNIT_W + 1;

   localparam int REQ_W    = 25;
   localparam int ADDR_W   = 32;
   localparam int STAT_W   = 3;
   localparam int PG_W     = 13;
   localparam int END_W    = 25;

   localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
   localparam logic [STAT_W-1:0] ST_TABLE_FULL = 3'd1;
   localparam logic [STAT_W-1:0] ST_HEAP_FULL  = 3'd2;
   localparam logic [STAT_W-1:0] ST_BAD_FREE   = 3'd3;
   localparam logic [STAT_W-1:0] ST_NULL_FREE  = 3'd4;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   typedef enum logic [4:0] {
      S_IDLE, S_RD, S_CHK, S_INS_RD, S_INS_WR, S_INS_FIN, S_MARK,
      S_APP_GROW, S_APP_CHK, S_NXT_RD, S_NXT_CHK, S_RM_RD, S_RM_WR,
      S_PRV_RD, S_PRV_CHK, S_FIN, S_RESP
   } state_type;

   typedef enum logic [4:0] {
      C_NONE, C_LOAD, C_RD_IDX, C_SCAN_STEP, C_HIT, C_SET_NULL, C_SET_BAD,
      C_SET_TFULL, C_SET_HFULL, C_RD_K, C_WR_UP, C_INS_FIN, C_MARK,
      C_APP_GROW, C_APP_COMMIT, C_RD_NEXT, C_MERGE_NEXT, C_RD_K1, C_WR_DN,
      C_RM_DONE, C_RD_PREV, C_MERGE_PREV, C_FREE_FIN, C_PUSH
   } cmd_type;

   typedef struct packed {
      logic is_free;
      logic null_free;
      logic scan_end;
      logic fit;
      logic used;
      logic match;
      logic split;
      logic ins_more;
      logic table_full;
      logic heap_over;
      logic has_next;
      logic rm_more;
      logic has_prev;
      logic out_free;
   } dp_status_type;

endpackage

>>> rtl/ffha_ctrl.sv
// Sequencer for the allocator: scan, shift, merge and response steps.
// Depends on ffha_pkg.
`timescale 1ns / 1ps

module ffha_ctrl
   import ffha_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type st,
   output cmd_type       cmd
);

   state_type state_ff, state_in;
   logic      phase_ff, phase_in;   // 0: merging with next, 1: merging with previous

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      unique case (state_ff)
         S_IDLE:     if (req_valid) state_in = S_RD;
         S_RD: begin
            priority if (st.null_free) state_in = S_RESP;
            else if (st.scan_end) begin
               priority if (st.is_free) state_in = S_RESP;
               else if (st.table_full) state_in = S_RESP;
               else state_in = S_APP_GROW;
            end else state_in = S_CHK;
         end
         S_CHK: begin
            if (st.is_free) begin
               priority if (st.match && st.used) state_in = S_NXT_RD;
               else if (st.match) state_in = S_RESP;
               else state_in = S_RD;
            end else begin
               priority if (st.fit && st.split) state_in = S_INS_RD;
               else if (st.fit) state_in = S_MARK;
               else state_in = S_RD;
            end
         end
         S_INS_RD:   state_in = st.ins_more ? S_INS_WR : S_MARK;
         S_INS_WR:   state_in = S_INS_RD;
         S_INS_FIN:  state_in = S_MARK;
         S_MARK:     state_in = S_RESP;
         S_APP_GROW: state_in = S_APP_CHK;
         S_APP_CHK:  state_in = S_RESP;
         S_NXT_RD:   state_in = st.has_next ? S_NXT_CHK : S_PRV_RD;
         S_NXT_CHK: begin
            if (!st.used) begin
               state_in = S_RM_RD;
               phase_in = 1'b0;
            end else state_in = S_PRV_RD;
         end
         S_RM_RD: begin
            if (st.rm_more) state_in = S_RM_WR;
            else state_in = phase_ff ? S_FIN : S_PRV_RD;
         end
         S_RM_WR:    state_in = S_RM_RD;
         S_PRV_RD:   state_in = st.has_prev ? S_PRV_CHK : S_FIN;
         S_PRV_CHK: begin
            if (!st.used) begin
               state_in = S_RM_RD;
               phase_in = 1'b1;
            end else state_in = S_FIN;
         end
         S_FIN:      state_in = S_RESP;
         S_RESP:     if (st.out_free) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = C_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd = C_LOAD;
         end
         S_RD: begin
            priority if (st.null_free) cmd = C_SET_NULL;
            else if (st.scan_end) begin
               priority if (st.is_free) cmd = C_SET_BAD;
               else if (st.table_full) cmd = C_SET_TFULL;
               else cmd = C_NONE;
            end else cmd = C_RD_IDX;
         end
         S_CHK: begin
            if (st.is_free) begin
               priority if (st.match && st.used) cmd = C_HIT;
               else if (st.match) cmd = C_SET_BAD;
               else cmd = C_SCAN_STEP;
            end else cmd = st.fit ? C_HIT : C_SCAN_STEP;
         end
         S_INS_RD:   cmd = st.ins_more ? C_RD_K : C_INS_FIN;
         S_INS_WR:   cmd = C_WR_UP;
         S_INS_FIN:  cmd = C_NONE;
         S_MARK:     cmd = C_MARK;
         S_APP_GROW: cmd = C_APP_GROW;
         S_APP_CHK:  cmd = st.heap_over ? C_SET_HFULL : C_APP_COMMIT;
         S_NXT_RD:   cmd = st.has_next ? C_RD_NEXT : C_NONE;
         S_NXT_CHK:  cmd = st.used ? C_NONE : C_MERGE_NEXT;
         S_RM_RD:    cmd = st.rm_more ? C_RD_K1 : C_RM_DONE;
         S_RM_WR:    cmd = C_WR_DN;
         S_PRV_RD:   cmd = st.has_prev ? C_RD_PREV : C_NONE;
         S_PRV_CHK:  cmd = st.used ? C_NONE : C_MERGE_PREV;
         S_FIN:      cmd = C_FREE_FIN;
         S_RESP:     cmd = st.out_free ? C_PUSH : C_NONE;
         default:    cmd = C_NONE;
      endcase
   end

endmodule

>>> rtl/ffha_dpath.sv
// Datapath: block table memory, scan offset, heap end and response register.
// Depends on ffha_pkg; driven by ffha_ctrl commands.
`timescale 1ns / 1ps

module ffha_dpath
   import ffha_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output dp_status_type     st,
   input  logic [ADDR_W-1:0] heap_base,
   input  logic              req_action,
   input  logic [REQ_W-1:0]  req_request_size,
   input  logic [ADDR_W-1:0] req_free_address,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [STAT_W-1:0] rsp_status,
   output logic [ADDR_W-1:0] rsp_payload_address,
   output logic [PG_W-1:0]   rsp_pages_grown,
   output logic [PG_W-1:0]   rsp_pages_released,
   output logic [END_W-1:0]  rsp_heap_end_offset
);

   logic [ENT_W-1:0] mem [MAX_BLOCKS];
   logic [ENT_W-1:0] rd_data_ff;

   logic              action_ff;
   logic [UNIT_W-1:0] need_ff, cur_ff;
   logic [ADDR_W-1:0] faddr_ff;
   logic [CNT_W-1:0]  idx_ff, k_ff, count_ff;
   logic [OFF_W-1:0]  off_ff;
   logic [TOP_W-1:0]  top_ff;
   logic [GROW_W-1:0] grow_ff;
   logic [STAT_W-1:0] res_status_ff;
   logic [ADDR_W-1:0] res_addr_ff;
   logic [PG_W-1:0]   res_grown_ff, res_rel_ff;
   logic              rsp_valid_ff;
   logic [STAT_W-1:0] rsp_status_ff;
   logic [ADDR_W-1:0] rsp_addr_ff;
   logic [PG_W-1:0]   rsp_grown_ff, rsp_rel_ff;
   logic [END_W-1:0]  rsp_end_ff;

   logic [UNIT_W-1:0] rd_units;
   logic              rd_used;
   logic [ADDR_W-1:0] pay_addr;
   logic [REQ_W:0]    need_sum;
   logic [OFF_W-1:0]  end_off, diff_off;
   logic [OFF_W:0]    new_top;
   logic [REL_W-1:0]  pg_blk;
   logic [TPG_W-1:0]  pg_top;
   logic [REL_W-1:0]  pg_rel;

   logic              rd_en, wr_en;
   logic [CNT_W-1:0]  raddr, waddr;
   logic [ENT_W-1:0]  wdata;

   assign rd_units = rd_data_ff[UNIT_W-1:0];
   assign rd_used  = rd_data_ff[UNIT_W];
   assign pay_addr = heap_base + ADDR_W'(off_ff) + ADDR_W'(16);
   assign need_sum = (REQ_W+1)'(req_request_size) + (REQ_W+1)'(31);
   assign end_off  = off_ff + OFF_W'({need_ff, 4'b0000});
   assign diff_off = end_off - OFF_W'(top_ff) + OFF_W'(PAGE_BYTES - 1);
   assign new_top  = (OFF_W+1)'(top_ff) + ((OFF_W+1)'(grow_ff) << PAGE_LOG);
   assign pg_blk   = cur_ff[UNIT_W-1:PAGE_LOG-4];
   assign pg_top   = top_ff[TOP_W-1:PAGE_LOG];
   assign pg_rel   = ((TPG_W)'(pg_blk) > pg_top) ? REL_W'(pg_top) : pg_blk;

   always_comb begin
      st.is_free    = action_ff;
      st.null_free  = (action_ff == ACT_FREE) && (faddr_ff == '0);
      st.scan_end   = idx_ff >= count_ff;
      st.fit        = !rd_used && (rd_units > need_ff);
      st.used       = rd_used;
      st.match      = pay_addr == faddr_ff;
      st.split      = ((rd_units - need_ff) > UNIT_W'(1)) &&
                      (count_ff < CNT_W'(MAX_BLOCKS));
      st.ins_more   = k_ff > idx_ff;
      st.table_full = count_ff >= CNT_W'(MAX_BLOCKS);
      st.heap_over  = new_top > (OFF_W+1)'(HEAP_BYTES);
      st.has_next   = (idx_ff + CNT_W'(1)) < count_ff;
      st.rm_more    = (k_ff + CNT_W'(1)) < count_ff;
      st.has_prev   = idx_ff != '0;
      st.out_free   = !rsp_valid_ff || rsp_ready;
   end

   // memory port selection
   always_comb begin
      rd_en = 1'b1;
      raddr = idx_ff;
      wr_en = 1'b0;
      waddr = idx_ff;
      wdata = {1'b0, cur_ff};
      unique case (cmd)
         C_RD_IDX:     raddr = idx_ff;
         C_RD_K:       raddr = k_ff;
         C_RD_K1:      raddr = k_ff + CNT_W'(1);
         C_RD_NEXT:    raddr = idx_ff + CNT_W'(1);
         C_RD_PREV:    raddr = idx_ff - CNT_W'(1);
         C_WR_UP: begin
            wr_en = 1'b1;
            waddr = k_ff + CNT_W'(1);
            wdata = rd_data_ff;
         end
         C_WR_DN: begin
            wr_en = 1'b1;
            waddr = k_ff;
            wdata = rd_data_ff;
         end
         C_INS_FIN: begin
            wr_en = 1'b1;
            waddr = idx_ff + CNT_W'(1);
            wdata = {1'b0, cur_ff - need_ff};
         end
         C_MARK: begin
            wr_en = 1'b1;
            wdata = {1'b1, cur_ff};
         end
         C_APP_COMMIT: begin
            wr_en = 1'b1;
            waddr = count_ff;
            wdata = {1'b1, need_ff};
         end
         C_FREE_FIN:   wr_en = 1'b1;
         default:      rd_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem[raddr[IDX_W-1:0]];
      if (wr_en) mem[waddr[IDX_W-1:0]] <= wdata;
   end

   // control state: table fill and heap end
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (cmd)
            C_INS_FIN:    count_ff <= count_ff + CNT_W'(1);
            C_APP_COMMIT: begin
               count_ff <= count_ff + CNT_W'(1);
               top_ff   <= new_top[TOP_W-1:0];
            end
            C_RM_DONE:    count_ff <= count_ff - CNT_W'(1);
            C_FREE_FIN: begin
               if ((idx_ff + CNT_W'(1)) == count_ff) begin
                  count_ff <= count_ff - CNT_W'(1);
                  top_ff   <= top_ff - (TOP_W'(pg_rel) << PAGE_LOG);
               end
            end
            default: ;
         endcase
         if (cmd == C_PUSH) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      unique case (cmd)
         C_LOAD: begin
            action_ff     <= req_action;
            // oversized request saturates: it can neither fit nor append
            need_ff       <= need_sum[REQ_W] ? '1 : need_sum[UNIT_W+3:4];
            faddr_ff      <= req_free_address;
            idx_ff        <= '0;
            off_ff        <= '0;
            res_status_ff <= ST_OK;
            res_addr_ff   <= '0;
            res_grown_ff  <= '0;
            res_rel_ff    <= '0;
         end
         C_SCAN_STEP: begin
            off_ff <= off_ff + OFF_W'({rd_units, 4'b0000});
            idx_ff <= idx_ff + CNT_W'(1);
         end
         C_HIT: begin
            cur_ff <= rd_units;
            k_ff   <= count_ff - CNT_W'(1);
         end
         C_SET_NULL:   res_status_ff <= ST_NULL_FREE;
         C_SET_BAD:    res_status_ff <= ST_BAD_FREE;
         C_SET_TFULL:  res_status_ff <= ST_TABLE_FULL;
         C_SET_HFULL:  res_status_ff <= ST_HEAP_FULL;
         C_WR_UP:      k_ff <= k_ff - CNT_W'(1);
         C_INS_FIN:    cur_ff <= need_ff;
         C_MARK:       res_addr_ff <= pay_addr;
         C_APP_GROW: begin
            if (end_off > OFF_W'(top_ff)) grow_ff <= diff_off[OFF_W-1:PAGE_LOG];
            else grow_ff <= '0;
         end
         C_APP_COMMIT: begin
            res_addr_ff  <= pay_addr;
            res_grown_ff <= grow_ff[PG_W-1:0];
         end
         C_MERGE_NEXT: begin
            cur_ff <= cur_ff + rd_units;
            k_ff   <= idx_ff + CNT_W'(1);
         end
         C_WR_DN:      k_ff <= k_ff + CNT_W'(1);
         C_MERGE_PREV: begin
            cur_ff <= cur_ff + rd_units;
            k_ff   <= idx_ff;
            idx_ff <= idx_ff - CNT_W'(1);
         end
         C_FREE_FIN: begin
            if ((idx_ff + CNT_W'(1)) == count_ff) res_rel_ff <= PG_W'(pg_rel);
         end
         C_PUSH: begin
            rsp_status_ff <= res_status_ff;
            rsp_addr_ff   <= res_addr_ff;
            rsp_grown_ff  <= res_grown_ff;
            rsp_rel_ff    <= res_rel_ff;
            rsp_end_ff    <= END_W'(top_ff);
         end
         default: ;
      endcase
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_payload_address = rsp_addr_ff;
   assign rsp_pages_grown     = rsp_grown_ff;
   assign rsp_pages_released  = rsp_rel_ff;
   assign rsp_heap_end_offset = rsp_end_ff;

endmodule

>>> rtl/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator: CSR port, sequencer, datapath.
// Depends on ffha_pkg, ffha_ctrl, ffha_dpath.
//
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_ready  | action, request_size, free_address
// rsp     | out       | rsp_valid/rsp_ready  | status, payload_address, pages, end
// csr     | in/out    | APB psel/penable     | heap_base at byte 0
//
// Steps: each block table entry scanned takes one single-port table read
//   and one check; each entry shifted on a split or merge takes a read and
//   a write; setup and response steps come on top.
// One item at a time; the next beat is taken while the last result waits.
// Reset: synchronous, active high; clears table fill, heap end, heap base.
// A stalled response holds the sequencer in its response step.
`timescale 1ns / 1ps

module first_fit_heap_allocator
   import ffha_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_action,
   input  logic [REQ_W-1:0]  req_request_size,
   input  logic [ADDR_W-1:0] req_free_address,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [STAT_W-1:0] rsp_status,
   output logic [ADDR_W-1:0] rsp_payload_address,
   output logic [PG_W-1:0]   rsp_pages_grown,
   output logic [PG_W-1:0]   rsp_pages_released,
   output logic [END_W-1:0]  rsp_heap_end_offset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic [ADDR_W-1:0] heap_base_ff;
   dp_status_type     st;
   cmd_type           cmd;

   // heap_base is the only register; word 1 reads zero and ignores writes
   always_ff @(posedge clock) begin
      if (reset) heap_base_ff <= '0;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == 1'b0)
         heap_base_ff <= csr_pwdata;
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? heap_base_ff : 32'd0;

   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   ffha_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .st                  (st),
      .heap_base           (heap_base_ff),
      .req_action          (req_action),
      .req_request_size    (req_request_size),
      .req_free_address    (req_free_address),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_payload_address (rsp_payload_address),
      .rsp_pages_grown     (rsp_pages_grown),
      .rsp_pages_released  (rsp_pages_released),
      .rsp_heap_end_offset (rsp_heap_end_offset)
   );

endmodule

>>> rtl/ffha_checker.sv
// Port-level checker for the first-fit heap allocator, bound to the top.
// Depends on ffha_pkg and first_fit_heap_allocator_macros.svh.
`timescale 1ns / 1ps
`include "first_fit_heap_allocator_macros.svh"

module ffha_checker
   import ffha_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [STAT_W-1:0] rsp_status,
   input logic [ADDR_W-1:0] rsp_payload_address,
   input logic [PG_W-1:0]   rsp_pages_grown,
   input logic [PG_W-1:0]   rsp_pages_released
);

   `FFHA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_payload_address))
   `FFHA_ASSERT_NOW(a_err_clean, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_payload_address == '0 && rsp_pages_grown == '0 && rsp_pages_released == '0)
   `FFHA_ASSERT_NOW(a_grow_xor_rel, clock, reset, rsp_valid && rsp_pages_grown != '0, rsp_pages_released == '0 && rsp_status == ST_OK)
   `FFHA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (.*);
